// ===== rtl/fbct_pkg.sv =====
// Shared types and constants for the frustum bound cull test.
package fbct_pkg;

  localparam int unsigned RegCount  = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned NormW     = 14;
  localparam int unsigned CoordW    = 22;
  localparam int unsigned RadiusW   = 21;
  localparam int unsigned FracShift = 12;  // Q13.8 offset scaled into Q.20
  localparam int unsigned ProdW     = NormW + CoordW;      // 36
  localparam int unsigned ValW      = ProdW + 3;           // 39, room for 3 products + offset
  localparam int unsigned DotW      = 2 * NormW + 2;       // 30

  typedef enum logic [1:0] {
    CmdPoint  = 2'd0,
    CmdSphere = 2'd1,
    CmdBox    = 2'd2,
    CmdBoxDir = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    VerdictInside     = 2'd0,
    VerdictIntersect  = 2'd1,
    VerdictOutside    = 2'd2,
    VerdictNotOutside = 2'd3
  } verdict_e;

  // Register packing: nx in the low bits, offset in the top bits.
  typedef struct packed {
    logic signed [CoordW-1:0] offset;
    logic signed [NormW-1:0]  nz;
    logic signed [NormW-1:0]  ny;
    logic signed [NormW-1:0]  nx;
  } plane_t;

  typedef struct packed {
    cmd_e                      cmd;
    logic signed [CoordW-1:0]  lo_x;
    logic signed [CoordW-1:0]  lo_y;
    logic signed [CoordW-1:0]  lo_z;
    logic signed [CoordW-1:0]  hi_x;
    logic signed [CoordW-1:0]  hi_y;
    logic signed [CoordW-1:0]  hi_z;
    logic        [RadiusW-1:0] radius;
    logic signed [NormW-1:0]   dir_x;
    logic signed [NormW-1:0]   dir_y;
    logic signed [NormW-1:0]   dir_z;
  } query_t;

  typedef struct packed {
    logic outside;  // this plane alone rejects the bound
    logic partial;  // bound reaches in front of this plane
  } lane_flags_t;

endpackage

// ===== rtl/fbct_plane_file.sv =====
// Plane registers written through the configuration port.
module fbct_plane_file
  import fbct_pkg::*;
#(
  parameter int unsigned NumPlanes = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output plane_t              planes_o [NumPlanes]
);

  plane_t planes_q [NumPlanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPlanes; i++) begin
        planes_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < NumPlanes; i++) begin
        if (cfg_idx_i == CfgIdxW'(i)) begin
          planes_q[i] <= plane_t'(cfg_data_i);
        end
      end
    end
  end

  assign planes_o = planes_q;

endmodule

// ===== rtl/fbct_plane_lane.sv =====
// One plane test: vertex select, plane value, direction check, per-plane flags.
module fbct_plane_lane
  import fbct_pkg::*;
(
  input  plane_t      plane_i,
  input  query_t      query_i,
  output lane_flags_t flags_o
);

  logic signed [CoordW-1:0] a_x, a_y, a_z;
  logic signed [CoordW-1:0] b_x, b_y, b_z;
  logic                     pos_x, pos_y, pos_z;
  logic signed [ProdW-1:0]  pa_x, pa_y, pa_z;
  logic signed [ProdW-1:0]  pb_x, pb_y, pb_z;
  logic signed [CoordW+FracShift-1:0] off_s;
  logic signed [ValW-1:0]   val_a, val_b, rad_s;
  logic signed [2*NormW-1:0] pd_x, pd_y, pd_z;
  logic signed [DotW-1:0]   dot;
  logic                     box_cmd, front_a, front_b, over_r, skip;

  assign pos_x = !plane_i.nx[NormW-1] && (|plane_i.nx);
  assign pos_y = !plane_i.ny[NormW-1] && (|plane_i.ny);
  assign pos_z = !plane_i.nz[NormW-1] && (|plane_i.nz);

  // Vertex A: center for point/sphere, n-vertex for boxes. Vertex B: p-vertex.
  assign box_cmd = query_i.cmd[1];
  assign a_x = (box_cmd && !pos_x) ? query_i.hi_x : query_i.lo_x;
  assign a_y = (box_cmd && !pos_y) ? query_i.hi_y : query_i.lo_y;
  assign a_z = (box_cmd && !pos_z) ? query_i.hi_z : query_i.lo_z;
  assign b_x = pos_x ? query_i.hi_x : query_i.lo_x;
  assign b_y = pos_y ? query_i.hi_y : query_i.lo_y;
  assign b_z = pos_z ? query_i.hi_z : query_i.lo_z;

  assign pa_x = plane_i.nx * a_x;
  assign pa_y = plane_i.ny * a_y;
  assign pa_z = plane_i.nz * a_z;
  assign pb_x = plane_i.nx * b_x;
  assign pb_y = plane_i.ny * b_y;
  assign pb_z = plane_i.nz * b_z;

  assign off_s = {plane_i.offset, {FracShift{1'b0}}};
  assign val_a = ValW'(pa_x) + ValW'(pa_y) + ValW'(pa_z) + ValW'(off_s);
  assign val_b = ValW'(pb_x) + ValW'(pb_y) + ValW'(pb_z) + ValW'(off_s);
  assign rad_s = ValW'({1'b0, query_i.radius, {FracShift{1'b0}}});

  assign pd_x = plane_i.nx * query_i.dir_x;
  assign pd_y = plane_i.ny * query_i.dir_y;
  assign pd_z = plane_i.nz * query_i.dir_z;
  assign dot  = DotW'(pd_x) + DotW'(pd_y) + DotW'(pd_z);

  assign front_a = (val_a > ValW'(0));
  assign front_b = (val_b > ValW'(0));
  assign over_r  = (val_a > rad_s);
  // planes facing away from the direction are left out
  assign skip    = (query_i.cmd == CmdBoxDir) && dot[DotW-1];

  always_comb begin
    flags_o = '0;
    case (query_i.cmd)
      CmdPoint: begin
        flags_o.outside = front_a;
      end
      CmdSphere: begin
        flags_o.outside = over_r;
        flags_o.partial = front_a;
      end
      CmdBox: begin
        flags_o.outside = front_a;
        flags_o.partial = front_b;
      end
      CmdBoxDir: begin
        flags_o.outside = front_a && !skip;
      end
      default: begin
        flags_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/frustum_bounds_cull_test.sv =====
// Top level of the frustum bound cull test: input register, plane lanes, result register.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+--------------------------------------
//   cfg      | cfg_we_i                       | cfg_idx_i, cfg_data_i
//   input    | in_valid_i / in_stall_o        | cmd_i, center_or_min_*, max_*, radius, dir_*
//   output   | out_valid_o / out_stall_i      | verdict_o
//
// One query per cycle while the output does not stall; a query passes the input register, then the result register.
// All planes are evaluated at once by parallel lanes between the two registers.
// Reset clears plane registers to zero and empties both stages.
// A stalled result holds; the input register still takes a transfer while it is free.
module frustum_bounds_cull_test
  import fbct_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic signed [CoordW-1:0] center_or_min_x_i,
  input  logic signed [CoordW-1:0] center_or_min_y_i,
  input  logic signed [CoordW-1:0] center_or_min_z_i,
  input  logic signed [CoordW-1:0] max_x_i,
  input  logic signed [CoordW-1:0] max_y_i,
  input  logic signed [CoordW-1:0] max_z_i,
  input  logic [RadiusW-1:0]       radius_i,
  input  logic signed [NormW-1:0]  dir_x_i,
  input  logic signed [NormW-1:0]  dir_y_i,
  input  logic signed [NormW-1:0]  dir_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               verdict_o
);

  // lanes are clamped to the register list; planes past it are not built and never reject anything
  localparam int unsigned NumPlanes = (PLANE_COUNT < RegCount) ? PLANE_COUNT : RegCount;

  plane_t      planes [NumPlanes];
  lane_flags_t flags  [NumPlanes];

  query_t   query_q, query_d;
  logic     in_vld_q, out_vld_q;
  verdict_e verdict_q, verdict_d;
  logic     adv_out, adv_in, any_out, any_part;

  fbct_plane_file #(
    .NumPlanes(NumPlanes)
  ) u_plane_file (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .planes_o  (planes)
  );

  for (genvar g = 0; g < NumPlanes; g++) begin : g_lane
    fbct_plane_lane u_lane (
      .plane_i(planes[g]),
      .query_i(query_q),
      .flags_o(flags[g])
    );
  end

  assign adv_out    = !out_vld_q || !out_stall_i;
  assign adv_in     = !in_vld_q || adv_out;
  assign in_stall_o = !adv_in;

  always_comb begin
    query_d        = query_q;
    query_d.cmd    = cmd_e'(cmd_i);
    query_d.lo_x   = center_or_min_x_i;
    query_d.lo_y   = center_or_min_y_i;
    query_d.lo_z   = center_or_min_z_i;
    query_d.hi_x   = max_x_i;
    query_d.hi_y   = max_y_i;
    query_d.hi_z   = max_z_i;
    query_d.radius = radius_i;
    query_d.dir_x  = dir_x_i;
    query_d.dir_y  = dir_y_i;
    query_d.dir_z  = dir_z_i;
  end

  always_comb begin
    any_out  = 1'b0;
    any_part = 1'b0;
    for (int i = 0; i < NumPlanes; i++) begin
      any_out  = any_out | flags[i].outside;
      any_part = any_part | flags[i].partial;
    end
    if (any_out) begin
      verdict_d = VerdictOutside;
    end else if (query_q.cmd == CmdBoxDir) begin
      verdict_d = VerdictNotOutside;
    end else if (any_part) begin
      verdict_d = VerdictIntersect;
    end else begin
      verdict_d = VerdictInside;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_vld_q <= in_valid_i;
      end
      if (adv_out) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      query_q <= query_d;
    end
    if (adv_out && in_vld_q) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign verdict_o   = verdict_q;

endmodule

// ===== sim/tb_frustum_bounds_cull_test.sv =====
// Self-checking testbench for the frustum bound cull test: random and directed queries.
`timescale 1ns / 1ps

module tb_frustum_bounds_cull_test;
  import fbct_pkg::*;

  localparam int unsigned PlaneLanes    = RegCount;
  localparam int          BoxHalf       = 25600;  // 100.0 in Q13.8
  localparam int          UnitNorm      = 1 <<< FracShift;
  localparam int          CoordMax      = (1 <<< (CoordW - 1)) - 1;
  localparam int          CoordMin      = -(1 <<< (CoordW - 1));
  localparam int          NormMax       = (1 <<< (NormW - 1)) - 1;
  localparam int          NormMin       = -(1 <<< (NormW - 1));
  localparam int unsigned RadiusMax     = (1 << RadiusW) - 1;
  localparam int unsigned HoldoffCycles = 300;

  localparam logic [CfgIdxW-1:0] IdxLeft  = 3'd0;
  localparam logic [CfgIdxW-1:0] IdxRight = 3'd1;
  localparam logic [CfgIdxW-1:0] IdxUp    = 3'd2;
  localparam logic [CfgIdxW-1:0] IdxDown  = 3'd3;
  localparam logic [CfgIdxW-1:0] IdxNear  = 3'd4;
  localparam logic [CfgIdxW-1:0] IdxFar   = 3'd5;

  typedef enum int unsigned {
    FrustumBox,
    FrustumExtreme,
    FrustumRandom,
    FrustumMixed
  } frustum_style_e;

  logic                     clk_i             = 1'b0;
  logic                     rst_ni            = 1'b0;
  logic                     cfg_we_i          = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i         = '0;
  logic [CfgDataW-1:0]      cfg_data_i        = '0;
  logic                     in_valid_i        = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               cmd_i             = '0;
  logic signed [CoordW-1:0] center_or_min_x_i = '0;
  logic signed [CoordW-1:0] center_or_min_y_i = '0;
  logic signed [CoordW-1:0] center_or_min_z_i = '0;
  logic signed [CoordW-1:0] max_x_i           = '0;
  logic signed [CoordW-1:0] max_y_i           = '0;
  logic signed [CoordW-1:0] max_z_i           = '0;
  logic [RadiusW-1:0]       radius_i          = '0;
  logic signed [NormW-1:0]  dir_x_i           = '0;
  logic signed [NormW-1:0]  dir_y_i           = '0;
  logic signed [NormW-1:0]  dir_z_i           = '0;
  logic                     out_valid_o;
  logic                     out_stall_i       = 1'b0;
  logic [1:0]               verdict_o;

  plane_t      plane_reg [PlaneLanes];
  query_t      pending_queries[$];
  verdict_e    expected_verdicts[$];
  query_t      offer;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          coord_span     = BoxHalf;
  int unsigned mismatches     = 0;
  int unsigned holdoff_left   = 0;
  bit          holdoff_req    = 1'b0;
  bit          holdoff_done   = 1'b0;

  frustum_bounds_cull_test #(
    .PLANE_COUNT(PlaneLanes)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .center_or_min_x_i(center_or_min_x_i),
    .center_or_min_y_i(center_or_min_y_i),
    .center_or_min_z_i(center_or_min_z_i),
    .max_x_i          (max_x_i),
    .max_y_i          (max_y_i),
    .max_z_i          (max_z_i),
    .radius_i         (radius_i),
    .dir_x_i          (dir_x_i),
    .dir_y_i          (dir_y_i),
    .dir_z_i          (dir_z_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .verdict_o        (verdict_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Signed plane value in Q.20, held exactly.
  function automatic longint plane_val(plane_t pl, longint px, longint py, longint pz);
    longint acc;
    acc = longint'($signed(pl.nx)) * px + longint'($signed(pl.ny)) * py
        + longint'($signed(pl.nz)) * pz;
    return acc + (longint'($signed(pl.offset)) <<< FracShift);
  endfunction

  function automatic verdict_e cull_verdict(query_t q);
    plane_t   pl;
    longint   lx, ly, lz, hx, hy, hz, nx, ny, nz, rad, val, dirdot;
    bit       hit;
    verdict_e v;
    lx  = $signed(q.lo_x);
    ly  = $signed(q.lo_y);
    lz  = $signed(q.lo_z);
    hx  = $signed(q.hi_x);
    hy  = $signed(q.hi_y);
    hz  = $signed(q.hi_z);
    rad = longint'(q.radius) <<< FracShift;
    hit = 1'b0;
    v   = (q.cmd == CmdBoxDir) ? VerdictNotOutside : VerdictInside;
    // outside is sticky, so later planes never need to be skipped
    for (int i = 0; i < PlaneLanes; i++) begin
      pl = plane_reg[i];
      nx = $signed(pl.nx);
      ny = $signed(pl.ny);
      nz = $signed(pl.nz);
      if (q.cmd == CmdPoint || q.cmd == CmdSphere) begin
        val = plane_val(pl, lx, ly, lz);
        if (val > 0) begin
          if (q.cmd == CmdPoint || val > rad) v = VerdictOutside;
          hit = 1'b1;
        end
      end else begin
        dirdot = longint'($signed(q.dir_x)) * nx + longint'($signed(q.dir_y)) * ny
               + longint'($signed(q.dir_z)) * nz;
        if (q.cmd == CmdBox || dirdot >= 0) begin
          // n-vertex takes min where the normal component is positive
          if (plane_val(pl, (nx > 0) ? lx : hx, (ny > 0) ? ly : hy,
                        (nz > 0) ? lz : hz) > 0)
            v = VerdictOutside;
          if (q.cmd == CmdBox &&
              plane_val(pl, (nx > 0) ? hx : lx, (ny > 0) ? hy : ly,
                        (nz > 0) ? hz : lz) > 0)
            hit = 1'b1;
        end
      end
    end
    if (v == VerdictInside && hit) v = VerdictIntersect;
    return v;
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return CoordW'($urandom_range(0, 1) ? CoordMax : CoordMin);
      1, 2:    return CoordW'($urandom);
      default: return CoordW'(int'($urandom_range(0, 2 * coord_span)) - coord_span);
    endcase
  endfunction

  function automatic logic signed [NormW-1:0] rand_dir();
    case ($urandom_range(0, 5))
      0:       return NormW'($urandom_range(0, 1) ? NormMax : NormMin);
      1:       return '0;
      default: return NormW'($urandom);
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    bit     ordered;
    q.cmd  = cmd_e'($urandom_range(0, 3));
    q.lo_x = rand_coord();
    q.lo_y = rand_coord();
    q.lo_z = rand_coord();
    q.hi_x = rand_coord();
    q.hi_y = rand_coord();
    q.hi_z = rand_coord();
    // mostly well-formed boxes; the rest keep their drawn order and may be inverted
    ordered = ($urandom_range(0, 9) != 0);
    if (ordered && $signed(q.lo_x) > $signed(q.hi_x)) {q.lo_x, q.hi_x} = {q.hi_x, q.lo_x};
    if (ordered && $signed(q.lo_y) > $signed(q.hi_y)) {q.lo_y, q.hi_y} = {q.hi_y, q.lo_y};
    if (ordered && $signed(q.lo_z) > $signed(q.hi_z)) {q.lo_z, q.hi_z} = {q.hi_z, q.lo_z};
    case ($urandom_range(0, 5))
      0:       q.radius = '0;
      1:       q.radius = RadiusW'(RadiusMax);
      2:       q.radius = RadiusW'($urandom);
      default: q.radius = RadiusW'($urandom_range(0, coord_span));
    endcase
    q.dir_x = rand_dir();
    q.dir_y = rand_dir();
    q.dir_z = rand_dir();
    return q;
  endfunction

  function automatic query_t mk_query(cmd_e c, int lx, int ly, int lz, int hx, int hy,
                                      int hz, int unsigned r, int dx, int dy, int dz);
    query_t q;
    q.cmd    = c;
    q.lo_x   = CoordW'(lx);
    q.lo_y   = CoordW'(ly);
    q.lo_z   = CoordW'(lz);
    q.hi_x   = CoordW'(hx);
    q.hi_y   = CoordW'(hy);
    q.hi_z   = CoordW'(hz);
    q.radius = RadiusW'(r);
    q.dir_x  = NormW'(dx);
    q.dir_y  = NormW'(dy);
    q.dir_z  = NormW'(dz);
    return q;
  endfunction

  function automatic logic signed [NormW-1:0] extreme_norm();
    case ($urandom_range(0, 2))
      0:       return NormW'(NormMin);
      1:       return NormW'(NormMax);
      default: return '0;
    endcase
  endfunction

  function automatic plane_t make_plane(frustum_style_e style, logic [CfgIdxW-1:0] idx,
                                        int half);
    plane_t pl;
    pl = '0;
    case (style)
      FrustumBox: begin
        pl.offset = CoordW'(-half);
        case (idx)
          IdxLeft:  pl.nx = NormW'(-UnitNorm);
          IdxRight: pl.nx = NormW'(UnitNorm);
          IdxUp:    pl.ny = NormW'(UnitNorm);
          IdxDown:  pl.ny = NormW'(-UnitNorm);
          IdxNear:  pl.nz = NormW'(-UnitNorm);
          default:  pl.nz = NormW'(UnitNorm);
        endcase
      end
      FrustumExtreme: begin
        pl.nx     = extreme_norm();
        pl.ny     = extreme_norm();
        pl.nz     = extreme_norm();
        pl.offset = CoordW'($urandom_range(0, 1) ? CoordMax : CoordMin);
      end
      FrustumRandom: pl = {$urandom, $urandom};
      default: begin
        pl.nx     = NormW'($urandom_range(0, 3) == 0 ? 0
                                                     : int'($urandom_range(0, 8192)) - 4096);
        pl.ny     = NormW'($urandom_range(0, 3) == 0 ? 0
                                                     : int'($urandom_range(0, 8192)) - 4096);
        pl.nz     = NormW'($urandom_range(0, 3) == 0 ? 0
                                                     : int'($urandom_range(0, 8192)) - 4096);
        pl.offset = CoordW'(int'($urandom_range(0, 4 * half)) - 3 * half);
      end
    endcase
    return pl;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < RegCount) plane_reg[idx] = val;
  endtask

  task automatic load_frustum(input frustum_style_e style, input int half);
    for (int i = IdxLeft; i <= IdxFar; i++)
      write_reg(CfgIdxW'(i), make_plane(style, CfgIdxW'(i), half));
    @(negedge clk_i);
  endtask

  task automatic push_random(input int unsigned count);
    repeat (count) pending_queries.push_back(rand_query());
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_queries.size() != 0 || in_valid_i || expected_verdicts.size() != 0);
  endtask

  // Queries against the axis-aligned box frustum of half-width BoxHalf.
  task automatic push_directed();
    int h;
    h = BoxHalf;
    pending_queries.push_back(mk_query(CmdPoint, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // on the plane is not in front
    pending_queries.push_back(mk_query(CmdPoint, h, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(mk_query(CmdPoint, h + 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(mk_query(CmdPoint, CoordMin, CoordMin, CoordMin,
                                       CoordMax, CoordMax, CoordMax, RadiusMax,
                                       NormMax, NormMax, NormMax));
    pending_queries.push_back(mk_query(CmdPoint, CoordMax, CoordMax, CoordMax,
                                       CoordMin, CoordMin, CoordMin, 0,
                                       NormMin, NormMin, NormMin));
    pending_queries.push_back(mk_query(CmdSphere, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // centre value equal to radius is intersect, one more is outside
    pending_queries.push_back(mk_query(CmdSphere, h + 100, 0, 0, 0, 0, 0, 100, 0, 0, 0));
    pending_queries.push_back(mk_query(CmdSphere, h + 101, 0, 0, 0, 0, 0, 100, 0, 0, 0));
    pending_queries.push_back(mk_query(CmdSphere, 0, 0, 0, 0, 0, 0, RadiusMax, 0, 0, 0));
    pending_queries.push_back(mk_query(CmdSphere, h - 10, 0, 0, 0, 0, 0, 50, 0, 0, 0));
    pending_queries.push_back(mk_query(CmdSphere, CoordMax, CoordMin, CoordMax,
                                       0, 0, 0, RadiusMax, 0, 0, 0));
    pending_queries.push_back(mk_query(CmdBox, -10, -10, -10, 10, 10, 10, 0, 0, 0, 0));
    pending_queries.push_back(mk_query(CmdBox, h - 10, -10, -10, h + 10, 10, 10, 0, 0, 0, 0));
    pending_queries.push_back(mk_query(CmdBox, h + 1, -10, -10, h + 50, 10, 10, 0, 0, 0, 0));
    pending_queries.push_back(mk_query(CmdBox, CoordMin, CoordMin, CoordMin,
                                       CoordMax, CoordMax, CoordMax, 0, 0, 0, 0));
    // inverted box
    pending_queries.push_back(mk_query(CmdBox, 10, 10, 10, -10, -10, -10, 0, 0, 0, 0));
    pending_queries.push_back(mk_query(CmdBox, h + 20, 0, 0, h - 20, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(mk_query(CmdBoxDir, h + 1, -10, -10, h + 50, 10, 10, 0,
                                       UnitNorm, 0, 0));
    // right plane faces away from the direction and is skipped
    pending_queries.push_back(mk_query(CmdBoxDir, h + 1, -10, -10, h + 50, 10, 10, 0,
                                       -UnitNorm, 0, 0));
    pending_queries.push_back(mk_query(CmdBoxDir, h + 1, -10, -10, h + 50, 10, 10, 0,
                                       0, 0, 0));
    pending_queries.push_back(mk_query(CmdBoxDir, -10, -10, -10, 10, 10, 10, 0,
                                       NormMin, NormMax, NormMin));
    pending_queries.push_back(mk_query(CmdBoxDir, CoordMin, CoordMin, CoordMin,
                                       CoordMax, CoordMax, CoordMax, 0,
                                       NormMax, NormMin, NormMax));
  endtask

  // Driver: predicts each transfer and offers the next pending query.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_verdicts.push_back(cull_verdict(offer));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_queries.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offer = pending_queries.pop_front();
          in_valid_i        <= 1'b1;
          cmd_i             <= offer.cmd;
          center_or_min_x_i <= offer.lo_x;
          center_or_min_y_i <= offer.lo_y;
          center_or_min_z_i <= offer.lo_z;
          max_x_i           <= offer.hi_x;
          max_y_i           <= offer.hi_y;
          max_z_i           <= offer.hi_z;
          radius_i          <= offer.radius;
          dir_x_i           <= offer.dir_x;
          dir_y_i           <= offer.dir_y;
          dir_z_i           <= offer.dir_z;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (holdoff_left != 0) begin
      out_stall_i  <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else if (holdoff_req && !holdoff_done) begin
      out_stall_i  <= 1'b1;
      holdoff_left = HoldoffCycles;
      holdoff_done = 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    verdict_e want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, got %0d", $time, verdict_o);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (verdict_o !== want) begin
          $display("%0t: verdict mismatch, expected %0d (%s), got %0d",
                   $time, want, want.name(), verdict_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < PlaneLanes; i++) plane_reg[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // planes still at their reset value
    push_random(10);
    wait_drained();

    load_frustum(FrustumBox, BoxHalf);
    push_directed();
    wait_drained();

    load_frustum(FrustumExtreme, BoxHalf);
    for (int i = RegCount; i < (1 << CfgIdxW); i++)
      write_reg(CfgIdxW'(i), {$urandom, $urandom});
    @(negedge clk_i);
    send_idle_pct = 86;
    push_random(70);
    wait_drained();

    load_frustum(FrustumRandom, BoxHalf);
    send_idle_pct  = 0;
    recv_stall_pct = 86;
    push_random(100);
    wait_drained();

    load_frustum(FrustumMixed, BoxHalf);
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    push_random(100);
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    load_frustum(FrustumBox, $urandom_range(256, 4 * BoxHalf));
    coord_span     = 4 * BoxHalf;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_req    = 1'b1;
    push_random(60);
    wait_drained();
    repeat (4) begin
      push_random(15);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fbct_pkg.sv
rtl/fbct_plane_file.sv
rtl/fbct_plane_lane.sv
rtl/frustum_bounds_cull_test.sv
sim/tb_frustum_bounds_cull_test.sv
